/* sv/mked_pkg.sv */
// Shared types and constants of the multi-key event detector.
package mked_pkg;

  // Field widths of the item channels
  localparam int LEVEL_W = 4;
  localparam int INDEX_W = 2;
  localparam int FLAG_W  = 6;

  // Configuration port geometry
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int LONG_W  = 16;
  localparam int DIV_W   = 8;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Flag bit positions
  localparam int BIT_HOLD   = 0;
  localparam int BIT_DOWN   = 1;
  localparam int BIT_UP     = 2;
  localparam int BIT_SINGLE = 3;
  localparam int BIT_LONG   = 4;
  localparam int BIT_REPEAT = 5;

  localparam logic [FLAG_W-1:0] FLAG_HOLD = 6'h01;

  // Register indexes (word address)
  localparam logic [1:0] REG_LONG_TIME     = 2'd0;
  localparam logic [1:0] REG_REPEAT_TIME   = 2'd1;
  localparam logic [1:0] REG_SAMPLE_DIVIDE = 2'd2;

  // Reset values of the registers
  localparam logic [LONG_W-1:0] LONG_TIME_RST     = 16'd100;
  localparam logic [LONG_W-1:0] REPEAT_TIME_RST   = 16'd10;
  localparam logic [DIV_W-1:0]  SAMPLE_DIVIDE_RST = 8'd2;

  // Per-key press state
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_PRESSED = 3'b010,
    MODE_LONG    = 3'b100
  } mode_t;

  // Control from the top level to one key cell
  typedef struct packed {
    logic              tick;
    logic              sample;
    logic              level;
    logic              clr;
    logic [FLAG_W-1:0] clr_mask;
  } key_ctrl_t;

endpackage

/* sv/mked_in_if.sv */
// Input item channel: tick or check command with its fields.
interface mked_in_if;
  import mked_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [LEVEL_W-1:0] key_levels;
  logic [INDEX_W-1:0] key_index;
  logic [FLAG_W-1:0]  flag_mask;

  modport source (output valid, cmd, key_levels, key_index, flag_mask, input ready);
  modport sink   (input valid, cmd, key_levels, key_index, flag_mask, output ready);
endinterface

/* sv/mked_out_if.sv */
// Result item channel: hit flag and the checked key's flags.
interface mked_out_if;
  import mked_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [FLAG_W-1:0] flags_seen;

  modport source (output valid, hit, flags_seen, input ready);
  modport sink   (input valid, hit, flags_seen, output ready);
endinterface

/* sv/mked_key.sv */
// One key cell: countdown, edge detection, press state machine and event flags.
module mked_key (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mked_pkg::key_ctrl_t        ctrl,
  input  logic [mked_pkg::LONG_W-1:0] long_time,
  input  logic [mked_pkg::LONG_W-1:0] repeat_time,
  output logic [mked_pkg::FLAG_W-1:0] flags
);
  import mked_pkg::*;

  logic              last_r, last_nxt;
  mode_t             mode_r, mode_nxt;
  logic [LONG_W-1:0] cd_r, cd_nxt, cd_dec;
  logic [FLAG_W-1:0] flags_r, flags_nxt;

  // Count down on every tick, stopping at zero
  always_comb begin
    cd_dec = cd_r;
    if (ctrl.tick && (cd_r != '0)) begin
      cd_dec = cd_r - LONG_W'(1);
    end
  end

  // Sample the level and step the press state machine; clear on check
  always_comb begin
    last_nxt  = last_r;
    mode_nxt  = mode_r;
    cd_nxt    = cd_dec;
    flags_nxt = flags_r;
    if (ctrl.clr) begin
      flags_nxt = flags_r & ~ctrl.clr_mask;
    end
    if (ctrl.sample) begin
      last_nxt = ctrl.level;
      flags_nxt[BIT_HOLD] = ctrl.level;
      if (ctrl.level && !last_r) flags_nxt[BIT_DOWN] = 1'b1;
      if (!ctrl.level && last_r) flags_nxt[BIT_UP] = 1'b1;
      unique case (mode_r)
        MODE_PRESSED: begin
          if (!ctrl.level) begin
            flags_nxt[BIT_SINGLE] = 1'b1;
            mode_nxt = MODE_IDLE;
          end else if (cd_dec == '0) begin
            cd_nxt = repeat_time;
            flags_nxt[BIT_LONG] = 1'b1;
            mode_nxt = MODE_LONG;
          end
        end
        MODE_LONG: begin
          if (!ctrl.level) begin
            mode_nxt = MODE_IDLE;
          end else if (cd_dec == '0) begin
            cd_nxt = repeat_time;
            flags_nxt[BIT_REPEAT] = 1'b1;
          end
        end
        default: begin
          if (ctrl.level) begin
            cd_nxt   = long_time;
            mode_nxt = MODE_PRESSED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      mode_r  <= MODE_IDLE;
      cd_r    <= '0;
      flags_r <= '0;
    end else begin
      last_r  <= last_nxt;
      mode_r  <= mode_nxt;
      cd_r    <= cd_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign flags = flags_r;

endmodule

/* sv/multi_key_event_detector.sv */
// Top level of the multi-key event detector: item pipeline, divider, registers.
//
// Detects press, release, single click, long press and auto-repeat on NUM_KEYS
// keys. A tick item (cmd 0) brings the key levels and advances every key's
// countdown; every sample_divide ticks the levels are sampled and the per-key
// flags and press state update. A check item (cmd 1) returns the named key's
// flags and whether any bit of flag_mask is set, and clears the masked bits
// unless the mask is hold alone. Every item gives exactly one result. The block
// takes one item per clock unless the result channel stalls. Each item is
// held in the input register, then in the result register; all per-key state
// updates when it moves from one to the other. Only keys 0 to 3 see levels
// and can be checked. Registers sit at byte addresses 0 (long_time),
// 4 (repeat_time) and 8 (sample_divide).
module multi_key_event_detector #(
  parameter int NUM_KEYS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mked_in_if.sink                     in_ch,
  mked_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mked_pkg::CFG_AW-1:0] paddr,
  input  logic [mked_pkg::CFG_DW-1:0] pwdata,
  output logic [mked_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import mked_pkg::*;

  // Configuration registers
  logic [LONG_W-1:0] long_time_r;
  logic [LONG_W-1:0] repeat_time_r;
  logic [DIV_W-1:0]  sample_divide_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  // Input register
  logic               s1_v_r;
  logic               s1_cmd_r;
  logic [LEVEL_W-1:0] s1_lvl_r;
  logic [INDEX_W-1:0] s1_idx_r;
  logic [FLAG_W-1:0]  s1_mask_r;

  // Result register
  logic              out_v_r;
  logic              out_hit_r, out_hit_nxt;
  logic [FLAG_W-1:0] out_flags_r, out_flags_nxt;

  logic              adv;
  logic              tick;
  logic              samp;
  logic [DIV_W-1:0]  div_r, div_nxt, div_inc;
  logic [FLAG_W-1:0] sel_flags;
  logic              hit_c;
  logic              clear_en;
  logic [FLAG_W-1:0] key_flags [NUM_KEYS];

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_time_r     <= LONG_TIME_RST;
      repeat_time_r   <= REPEAT_TIME_RST;
      sample_divide_r <= SAMPLE_DIVIDE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LONG_TIME:     long_time_r     <= pwdata[LONG_W-1:0];
        REG_REPEAT_TIME:   repeat_time_r   <= pwdata[LONG_W-1:0];
        REG_SAMPLE_DIVIDE: sample_divide_r <= pwdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LONG_TIME:     prdata = CFG_DW'(long_time_r);
      REG_REPEAT_TIME:   prdata = CFG_DW'(repeat_time_r);
      REG_SAMPLE_DIVIDE: prdata = CFG_DW'(sample_divide_r);
      default:           prdata = '0;
    endcase
  end

  // Advance the item in the input register when the result slot frees
  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_lvl_r  <= in_ch.key_levels;
      s1_idx_r  <= in_ch.key_index;
      s1_mask_r <= in_ch.flag_mask;
    end
  end

  // Tick divider: sample when the incremented count reaches sample_divide
  assign tick    = adv && (s1_cmd_r == CMD_TICK);
  assign div_inc = div_r + DIV_W'(1);
  assign samp    = (div_inc >= sample_divide_r);

  always_comb begin
    div_nxt = div_r;
    if (tick) begin
      div_nxt = samp ? '0 : div_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

  // Select the checked key's flags; keys that do not exist read as zero
  always_comb begin
    sel_flags = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ({2'b00, s1_idx_r} == 4'(k)) sel_flags = key_flags[k];
    end
  end

  assign hit_c    = |(sel_flags & s1_mask_r);
  assign clear_en = adv && (s1_cmd_r == CMD_CHECK) && hit_c && (s1_mask_r != FLAG_HOLD);

  // Key cells
  for (genvar gk = 0; gk < NUM_KEYS; gk++) begin : g_key
    key_ctrl_t ctrl;
    logic      lvl;

    if (gk < LEVEL_W) begin : g_lvl
      assign lvl = s1_lvl_r[gk];
    end else begin : g_nolvl
      assign lvl = 1'b0;
    end

    assign ctrl.tick     = tick;
    assign ctrl.sample   = tick && samp;
    assign ctrl.level    = lvl;
    assign ctrl.clr      = clear_en && ({2'b00, s1_idx_r} == 4'(gk));
    assign ctrl.clr_mask = s1_mask_r;

    mked_key u_key (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .long_time   (long_time_r),
      .repeat_time (repeat_time_r),
      .flags       (key_flags[gk])
    );
  end

  // Result: zeros for a tick, flags and hit for a check
  always_comb begin
    out_hit_nxt   = 1'b0;
    out_flags_nxt = '0;
    if (s1_cmd_r == CMD_CHECK) begin
      out_hit_nxt   = hit_c;
      out_flags_nxt = sel_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r   <= out_hit_nxt;
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.flags_seen = out_flags_r;

  // A hit always comes with at least one flag shown
  a_hit_has_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_hit_r) |-> (out_flags_r != '0))
    else $error("hit reported with no flags set");

  // An advanced item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("advanced item missing from result register");

  // A held item stays in the input register
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("stalled item dropped from input register");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Testbench of the multi-key event detector: key traffic checked against a flag predictor.
module testbench;
  import mked_pkg::*;

  localparam int LIMIT = 100000;

  // Flag predictor and store of expected results
  class key_flag_board;
    logic [LONG_W-1:0] long_load, repeat_load;
    logic [DIV_W-1:0]  divide, div_count;
    logic [LONG_W-1:0] timer [LEVEL_W];
    logic              prev_lvl [LEVEL_W];
    mode_t             mode [LEVEL_W];
    logic [FLAG_W-1:0] flags [LEVEL_W];
    logic [FLAG_W:0]   expected_results [$];  // {hit, flags_seen}
    int errors, results, ticks, checks, n_single, n_long, n_repeat;

    function new();
      long_load   = LONG_TIME_RST;
      repeat_load = REPEAT_TIME_RST;
      divide      = SAMPLE_DIVIDE_RST;
      div_count   = '0;
      for (int k = 0; k < LEVEL_W; k++) begin
        prev_lvl[k] = 1'b0;
        mode[k]     = MODE_IDLE;
        timer[k]    = '0;
        flags[k]    = '0;
      end
    endfunction

    // Mirror a register write
    function void set_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_LONG_TIME:     long_load = value[LONG_W-1:0];
        REG_REPEAT_TIME:   repeat_load = value[LONG_W-1:0];
        REG_SAMPLE_DIVIDE: divide = value[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    // Update one key's flags and press state from a sampled level
    function void sample_key(int k, logic lvl);
      logic [FLAG_W-1:0] f;
      f = flags[k];
      f[BIT_HOLD] = lvl;
      if (lvl && !prev_lvl[k]) f[BIT_DOWN] = 1'b1;
      if (!lvl && prev_lvl[k]) f[BIT_UP] = 1'b1;
      prev_lvl[k] = lvl;
      case (mode[k])
        MODE_PRESSED: begin
          if (!lvl) begin
            f[BIT_SINGLE] = 1'b1;
            mode[k] = MODE_IDLE;
          end else if (timer[k] == '0) begin
            timer[k] = repeat_load;
            f[BIT_LONG] = 1'b1;
            mode[k] = MODE_LONG;
          end
        end
        MODE_LONG: begin
          if (!lvl) begin
            mode[k] = MODE_IDLE;
          end else if (timer[k] == '0) begin
            timer[k] = repeat_load;
            f[BIT_REPEAT] = 1'b1;
          end
        end
        default: begin
          if (lvl) begin
            timer[k] = long_load;
            mode[k] = MODE_PRESSED;
          end
        end
      endcase
      flags[k] = f;
    endfunction

    // Predict the result of one accepted item
    function void note_item(logic cmd, logic [LEVEL_W-1:0] levels,
                            logic [INDEX_W-1:0] idx, logic [FLAG_W-1:0] mask);
      logic [FLAG_W-1:0] f;
      logic              any;
      if (cmd == CMD_TICK) begin
        ticks++;
        for (int k = 0; k < LEVEL_W; k++)
          if (timer[k] != '0) timer[k]--;
        div_count++;
        if (div_count >= divide) begin
          div_count = '0;
          for (int k = 0; k < LEVEL_W; k++) sample_key(k, levels[k]);
        end
        expected_results.push_back('0);
      end else begin
        checks++;
        f   = flags[idx];
        any = |(f & mask);
        expected_results.push_back({any, f});
        if (any && mask != FLAG_HOLD) flags[idx] = f & ~mask;
        n_single += f[BIT_SINGLE];
        n_long   += f[BIT_LONG];
        n_repeat += f[BIT_REPEAT];
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic hit, logic [FLAG_W-1:0] seen);
      logic [FLAG_W:0] want;
      results++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
        return;
      end
      want = expected_results.pop_front();
      if (hit !== want[FLAG_W])
        report($sformatf("result %0d hit %b, expected %b", results, hit, want[FLAG_W]));
      if (seen !== want[FLAG_W-1:0])
        report($sformatf("result %0d flags_seen %h, expected %h", results, seen,
                         want[FLAG_W-1:0]));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic              stall_en;
  int                cycles = 0;
  int                settings_run = 0;
  key_flag_board     board;

  mked_in_if  in_ch ();
  mked_out_if out_ch ();

  multi_key_event_detector #(.NUM_KEYS(4)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ch.ready <= !stall_en || ($urandom_range(99) >= 12);
  end

  // Check results first, then predict from accepted items
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.hit, out_ch.flags_seen);
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_item(in_ch.cmd, in_ch.key_levels, in_ch.key_index, in_ch.flag_mask);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic c, input logic [LEVEL_W-1:0] lv,
                           input logic [INDEX_W-1:0] ix, input logic [FLAG_W-1:0] mk);
    while (stall_en && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.key_levels <= lv;
    in_ch.key_index  <= ix;
    in_ch.flag_mask  <= mk;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Read a register and compare it with the value it should hold
  task automatic check_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want)
      board.report($sformatf("register %0d reads %h, expected %h", idx, got, want));
  endtask

  // Write a register, mirror it in the predictor, read it back
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
    check_reg(idx, value);
  endtask

  // Apply one register setting while the block is idle
  task automatic configure(input int lt, input int rt, input int sd);
    drain();
    write_reg(REG_LONG_TIME, CFG_DW'(lt));
    write_reg(REG_REPEAT_TIME, CFG_DW'(rt));
    write_reg(REG_SAMPLE_DIVIDE, CFG_DW'(sd));
    settings_run++;
  endtask

  // Pick a check mask: hold alone, empty, one flag or any mix
  function automatic logic [FLAG_W-1:0] pick_mask();
    int r;
    r = $urandom_range(99);
    if (r < 20) return FLAG_HOLD;
    if (r < 30) return '0;
    if (r < 60) return FLAG_W'(1) << $urandom_range(FLAG_W - 1);
    return FLAG_W'($urandom_range(63));
  endfunction

  // Press and release keys in held runs with checks interleaved; some bounce
  task automatic run_keys(input int count);
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] lv;
    int                 r;
    held = '0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_item(CMD_CHECK, LEVEL_W'($urandom_range(15)),
                  INDEX_W'($urandom_range(3)), pick_mask());
      end else begin
        if ($urandom_range(99) < 10) held[$urandom_range(LEVEL_W - 1)] ^= 1'b1;
        if ($urandom_range(99) < 2) held = '0;
        lv = held;
        if ($urandom_range(99) < 8) lv = LEVEL_W'($urandom_range(15));
        send_item(CMD_TICK, lv, INDEX_W'($urandom_range(3)), FLAG_W'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    int lts [8] = '{4, 1, 12, 1, 65535, 2, 6, 3};
    int rts [8] = '{2, 1, 3, 1, 65535, 65535, 1, 5};
    int sds [8] = '{1, 1, 2, 255, 3, 1, 4, 1};
    int cnt [8] = '{150, 150, 250, 150, 120, 140, 180, 160};

    board = new();
    stall_en         <= 1'b1;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.key_levels <= '0;
    in_ch.key_index  <= '0;
    in_ch.flag_mask  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers come out of reset at their defaults
    check_reg(REG_LONG_TIME, CFG_DW'(LONG_TIME_RST));
    check_reg(REG_REPEAT_TIME, CFG_DW'(REPEAT_TIME_RST));
    check_reg(REG_SAMPLE_DIVIDE, CFG_DW'(SAMPLE_DIVIDE_RST));

    // Directed: press all, long then repeat, release, short click, masks
    configure(2, 1, 1);
    send_item(CMD_CHECK, '0, 2'd0, 6'h3F);
    send_item(CMD_CHECK, '0, 2'd3, 6'h00);
    send_item(CMD_TICK, 4'hF, 2'd0, 6'h00);
    send_item(CMD_CHECK, '0, 2'd0, FLAG_HOLD);
    send_item(CMD_CHECK, '0, 2'd0, FLAG_HOLD);
    send_item(CMD_CHECK, '0, 2'd1, 6'h00);
    send_item(CMD_TICK, 4'hF, 2'd3, 6'h3F);
    send_item(CMD_TICK, 4'hF, 2'd0, 6'h00);
    send_item(CMD_TICK, 4'hF, 2'd0, 6'h00);
    send_item(CMD_CHECK, '0, 2'd2, 6'h30);
    send_item(CMD_CHECK, '0, 2'd2, 6'h3F);
    send_item(CMD_TICK, 4'h0, 2'd0, 6'h00);
    send_item(CMD_CHECK, 4'hF, 2'd0, 6'h3F);
    send_item(CMD_TICK, 4'hA, 2'd0, 6'h00);
    send_item(CMD_TICK, 4'h0, 2'd0, 6'h00);
    send_item(CMD_CHECK, '0, 2'd1, 6'h08);
    send_item(CMD_CHECK, '0, 2'd3, 6'h3F);
    send_item(CMD_TICK, 4'h5, 2'd3, 6'h3F);
    send_item(CMD_CHECK, '0, 2'd2, 6'h02);
    send_item(CMD_CHECK, '0, 2'd0, 6'h3F);

    // Random phases, one per register setting; one runs without stalls
    for (int p = 0; p < 8; p++) begin
      configure(lts[p], rts[p], sds[p]);
      stall_en <= (p != 2);
      @(posedge clk);
      run_keys(cnt[p]);
    end

    drain();
    $display("Summary: %0d items (%0d ticks, %0d checks) over %0d register settings",
             board.ticks + board.checks, board.ticks, board.checks, settings_run);
    $display("Summary: checks reported single %0d, long %0d, repeat %0d times",
             board.n_single, board.n_long, board.n_repeat);
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
